/* rtl/core/sync_length_frame_receiver_top_assert.svh */
// Assertion macros used by the frame receiver parser module.
`ifndef SYNC_LENGTH_FRAME_RECEIVER_TOP_ASSERT_SVH
`define SYNC_LENGTH_FRAME_RECEIVER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define SLFR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SLFR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SLFR_ASSERT(label, prop, msg)
`define SLFR_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

/* rtl/core/slfr_pkg.sv */
`timescale 1ns / 1ps

package slfr_pkg;

  localparam logic [7:0]  SYNC_FIRST_RESET  = 8'hAA;
  localparam logic [7:0]  SYNC_SECOND_RESET = 8'h55;
  localparam logic [16:0] FRAME_LIMIT_RESET = 17'd1024;
  localparam logic [16:0] LIMIT_CAP         = 17'd65536;
  localparam logic [16:0] FRAME_OVERHEAD    = 17'd9;
  localparam logic [15:0] LEN_LO_OFFSET     = 16'd5;
  localparam logic [15:0] LEN_HI_OFFSET     = 16'd6;

  typedef enum logic [1:0] {
    CFG_SYNC_FIRST  = 2'd0,
    CFG_SYNC_SECOND = 2'd1,
    CFG_FRAME_LIMIT = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    PH_HUNT   = 2'd0,
    PH_LENGTH = 2'd1,
    PH_BODY   = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ST_DROP   = 2'd0,
    ST_ACCEPT = 2'd1,
    ST_LAST   = 2'd2,
    ST_REJECT = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0]  sync_first;
    logic [7:0]  sync_second;
    logic [16:0] frame_limit;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [15:0] frame_offset;
    status_t     status;
    logic [16:0] total_length;
  } res_t;

endpackage

/* rtl/core/slfr_cfg_regs.sv */
`timescale 1ns / 1ps

module slfr_cfg_regs (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [1:0]        cfg_index,
  input  logic [16:0]       cfg_data,
  output slfr_pkg::cfg_t    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_first  <= slfr_pkg::SYNC_FIRST_RESET;
      cfg.sync_second <= slfr_pkg::SYNC_SECOND_RESET;
      cfg.frame_limit <= slfr_pkg::FRAME_LIMIT_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        slfr_pkg::CFG_SYNC_FIRST: begin
          cfg.sync_first <= cfg_data[7:0];
        end
        slfr_pkg::CFG_SYNC_SECOND: begin
          cfg.sync_second <= cfg_data[7:0];
        end
        slfr_pkg::CFG_FRAME_LIMIT: begin
          cfg.frame_limit <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

/* rtl/core/slfr_in_reg.sv */
`timescale 1ns / 1ps

module slfr_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // rx_byte[7:0]
  input  logic       take,
  output logic       valid,
  output logic [7:0] rx_byte
);

  assign s_tready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      valid <= 1'b1;
    end else if (take) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      rx_byte <= s_tdata;
    end
  end

endmodule

/* rtl/core/slfr_parser.sv */
`timescale 1ns / 1ps

module slfr_parser (
  input  logic           clk,
  input  logic           rst,
  input  slfr_pkg::cfg_t cfg,
  input  logic           fire,
  input  logic [7:0]     rx_byte,
  output slfr_pkg::res_t res
);

  slfr_pkg::phase_t phase;
  slfr_pkg::phase_t phase_next;
  logic [15:0]      byte_count;
  logic [15:0]      byte_count_next;
  logic [7:0]       length_low_byte;
  logic [7:0]       length_low_byte_next;
  logic [16:0]      expected_total;
  logic [16:0]      expected_total_next;

  logic [16:0]      limit;
  logic             bound_hit;
  slfr_pkg::phase_t cur_phase;
  logic [15:0]      cur_count;
  logic [16:0]      cur_expected;
  logic [15:0]      count_inc;
  logic [16:0]      hdr_total;
  logic             too_long;
  logic             body_done;
  logic             match_first;
  logic             match_second;
  slfr_pkg::status_t status;
  logic [16:0]      total_out;

  // The byte count is checked against the limit before the byte is handled.
  assign limit        = (cfg.frame_limit > slfr_pkg::LIMIT_CAP) ? slfr_pkg::LIMIT_CAP
                                                                 : cfg.frame_limit;
  assign bound_hit    = ({1'b0, byte_count} >= limit);
  assign cur_phase    = bound_hit ? slfr_pkg::PH_HUNT : phase;
  assign cur_count    = bound_hit ? 16'd0 : byte_count;
  assign cur_expected = bound_hit ? 17'd0 : expected_total;
  assign count_inc    = cur_count + 16'd1;
  assign hdr_total    = slfr_pkg::FRAME_OVERHEAD + {9'd0, length_low_byte}
                        + {1'b0, rx_byte, 8'd0};
  assign too_long     = (hdr_total >= limit);
  assign body_done    = ({1'b0, count_inc} == cur_expected);
  assign match_first  = (rx_byte == cfg.sync_first);
  assign match_second = (rx_byte == cfg.sync_second);

  always_comb begin
    phase_next           = cur_phase;
    byte_count_next      = cur_count;
    length_low_byte_next = length_low_byte;
    expected_total_next  = cur_expected;
    case (cur_phase)
      slfr_pkg::PH_LENGTH: begin
        byte_count_next = count_inc;
        if (cur_count == slfr_pkg::LEN_LO_OFFSET) begin
          length_low_byte_next = rx_byte;
        end else if (cur_count == slfr_pkg::LEN_HI_OFFSET) begin
          if (too_long) begin
            phase_next          = slfr_pkg::PH_HUNT;
            byte_count_next     = 16'd0;
            expected_total_next = 17'd0;
          end else begin
            phase_next          = slfr_pkg::PH_BODY;
            expected_total_next = hdr_total;
          end
        end
      end
      slfr_pkg::PH_BODY: begin
        byte_count_next = count_inc;
        if (body_done) begin
          phase_next          = slfr_pkg::PH_HUNT;
          byte_count_next     = 16'd0;
          expected_total_next = 17'd0;
        end
      end
      default: begin
        phase_next = slfr_pkg::PH_HUNT;
        if (cur_count == 16'd0) begin
          byte_count_next = match_first ? 16'd1 : 16'd0;
        end else if (match_second) begin
          phase_next      = slfr_pkg::PH_LENGTH;
          byte_count_next = 16'd2;
        end else begin
          byte_count_next     = 16'd0;
          expected_total_next = 17'd0;
        end
      end
    endcase
  end

  always_comb begin
    status    = slfr_pkg::ST_ACCEPT;
    total_out = 17'd0;
    case (cur_phase)
      slfr_pkg::PH_LENGTH: begin
        if (cur_count == slfr_pkg::LEN_HI_OFFSET) begin
          total_out = hdr_total;
          status    = too_long ? slfr_pkg::ST_REJECT : slfr_pkg::ST_ACCEPT;
        end
      end
      slfr_pkg::PH_BODY: begin
        total_out = cur_expected;
        status    = body_done ? slfr_pkg::ST_LAST : slfr_pkg::ST_ACCEPT;
      end
      default: begin
        if (cur_count == 16'd0) begin
          status = match_first ? slfr_pkg::ST_ACCEPT : slfr_pkg::ST_DROP;
        end else begin
          status = match_second ? slfr_pkg::ST_ACCEPT : slfr_pkg::ST_DROP;
        end
      end
    endcase
  end

  assign res.out_byte     = rx_byte;
  assign res.frame_offset = cur_count;
  assign res.status       = status;
  assign res.total_length = total_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= slfr_pkg::PH_HUNT;
      byte_count      <= 16'd0;
      length_low_byte <= 8'd0;
      expected_total  <= 17'd0;
    end else if (fire) begin
      phase           <= phase_next;
      byte_count      <= byte_count_next;
      length_low_byte <= length_low_byte_next;
      expected_total  <= expected_total_next;
    end
  end

`include "sync_length_frame_receiver_top_assert.svh"

  `SLFR_ASSERT(a_hunt_count_small, (phase == slfr_pkg::PH_HUNT) |-> (byte_count <= 16'd1), "byte count too large while hunting")
  `SLFR_ASSERT(a_body_below_total, (phase == slfr_pkg::PH_BODY) |-> ({1'b0, byte_count} < expected_total), "body count reached expected total")
  `SLFR_ASSERT(a_reject_restarts, (fire && status == slfr_pkg::ST_REJECT) |=> (phase == slfr_pkg::PH_HUNT && byte_count == 16'd0), "rejected frame did not restart hunting")
  `SLFR_ASSERT(a_last_matches_total, (fire && status == slfr_pkg::ST_LAST) |-> ({1'b0, cur_count} + 17'd1 == total_out), "last byte offset disagrees with total")

endmodule

/* rtl/core/slfr_out_reg.sv */
`timescale 1ns / 1ps

module slfr_out_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  slfr_pkg::res_t res,
  output logic           load_ready,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [47:0]    m_tdata,   // out_byte[7:0], frame_offset[15:0], total_length[16:0], zero pad
  output logic [1:0]     m_tuser    // status[1:0]
);

  assign load_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {7'd0, res.total_length, res.frame_offset, res.out_byte};
      m_tuser <= res.status;
    end
  end

endmodule

/* rtl/core/sync_length_frame_receiver_top.sv */
`timescale 1ns / 1ps

// Byte-serial deframer for frames that open with a two-byte sync header and
// carry a little-endian payload length at frame offsets 5 and 6.
// Received bytes enter on the slave stream, one byte per transaction in
// s_tdata. Every byte yields exactly one result transaction on the master
// stream: the byte, its frame offset and the total frame length in m_tdata,
// and its status (dropped, accepted, last of frame, rejected) in m_tuser.
// The sync bytes and frame length limit go in through the configuration port;
// the user must write them only with no byte in flight; the block does not check.
// A result passes from the input register through the parser logic into the
// output register, which presents it on m_tvalid. Throughput is one byte per
// cycle while m_tready stays high, set by the single parser stage between the
// input register and the output register.
// When the receiver deasserts m_tready the output register holds its result,
// the input register takes one more byte only if it is empty, and s_tready
// then drops until the output register is drained.
// Reset clears both registers' valid flags, returns the parser to header
// hunting and restores the default configuration.
module sync_length_frame_receiver_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // rx_byte[7:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,    // out_byte[7:0], frame_offset[15:0], total_length[16:0], zero pad
  output logic [1:0]  m_tuser,    // status[1:0]
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data
);

  slfr_pkg::cfg_t cfg;
  slfr_pkg::res_t res;
  logic           in_valid;
  logic [7:0]     rx_byte;
  logic           load_ready;
  logic           fire;

  assign fire = in_valid && load_ready;

  slfr_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  slfr_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .take     (fire),
    .valid    (in_valid),
    .rx_byte  (rx_byte)
  );

  slfr_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .fire    (fire),
    .rx_byte (rx_byte),
    .res     (res)
  );

  slfr_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .load       (fire),
    .res        (res),
    .load_ready (load_ready),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser)
  );

endmodule
